// ===== design/ss7_pkg.sv =====
// Shared types, segment codes and constants for the seven-segment converter.
`timescale 1ns / 1ps

package ss7_pkg;

    localparam int SEG_W    = 7;
    localparam int REM_W    = 14;
    localparam int DIGIT_W  = 4;
    localparam int NUM_POS  = 4;
    localparam int VALUE_W  = 16;

    localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

    localparam logic signed [VALUE_W-1:0] MAX_POS_VALUE = 16'sd9999;
    localparam logic signed [VALUE_W-1:0] MIN_NEG_VALUE = -16'sd999;

    localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Multiples of one thousand, the place weight every cell works on.
    localparam logic [REM_W-1:0] KILO [10] = '{
        14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
        14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000
    };

    // Error word "Erro", leftmost position first.
    localparam logic [SEG_W-1:0] ERR_SEG [NUM_POS] = '{7'h79, 7'h50, 7'h50, 7'h5C};

    typedef logic [NUM_POS-1:0][SEG_W-1:0] seg_vec_t;

    typedef struct packed {
        logic             err;
        logic             neg;
        logic             leading;
        logic [REM_W-1:0] rem;
        seg_vec_t         segs;
    } ss7_word_t;

endpackage

// ===== design/signed_int_to_seven_segment.sv =====
// Top level: range check, magnitude, a row of four digit cells and the output patterns.
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  input   | s_valid, s_ready, s_value               | in
//  result  | m_valid, m_ready, m_seg_pos0..m_seg_pos3 | out
//
// A word passes an entry register and four digit cells, each of which registers it,
// and its result is presented from the last cell; one word is taken every cycle
// while no stall on m_ready holds the chain.
// Each cell holds its own word, so a stall on m_ready only fills the empty
// stages and the chain keeps accepting until every stage is occupied.
// Reset clears the valid bits of all stages; nothing else needs clearing.
`timescale 1ns / 1ps

module signed_int_to_seven_segment (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ss7_pkg::VALUE_W-1:0]    s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ss7_pkg::SEG_W-1:0]             m_seg_pos0,
    output logic [ss7_pkg::SEG_W-1:0]             m_seg_pos1,
    output logic [ss7_pkg::SEG_W-1:0]             m_seg_pos2,
    output logic [ss7_pkg::SEG_W-1:0]             m_seg_pos3
);
    import ss7_pkg::*;

    logic      entry_valid_reg;
    ss7_word_t entry_word_reg;
    ss7_word_t entry_word_next;

    logic      chain_valid [NUM_POS+1];
    logic      chain_ready [NUM_POS+1];
    ss7_word_t chain_word  [NUM_POS+1];

    ss7_word_t last_word;

    assign s_ready = !entry_valid_reg || chain_ready[0];

    always_comb begin
        entry_word_next.err     = (s_value < MIN_NEG_VALUE) || (s_value > MAX_POS_VALUE);
        entry_word_next.neg     = s_value[VALUE_W-1];
        entry_word_next.leading = 1'b1;
        // Out-of-range words carry a zero remainder; their patterns are replaced.
        if (entry_word_next.err) begin
            entry_word_next.rem = '0;
        end else if (s_value[VALUE_W-1]) begin
            entry_word_next.rem = REM_W'(-s_value);
        end else begin
            entry_word_next.rem = REM_W'(s_value);
        end
        entry_word_next.segs = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
        end else if (s_ready) begin
            entry_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            entry_word_reg <= entry_word_next;
        end
    end

    assign chain_valid[0] = entry_valid_reg;
    assign chain_word[0]  = entry_word_reg;

    for (genvar i = 0; i < NUM_POS; i++) begin : g_cell
        ss7_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    assign chain_ready[NUM_POS] = m_ready;
    assign m_valid              = chain_valid[NUM_POS];
    assign last_word            = chain_word[NUM_POS];

    // The first cell's pattern has been shifted to the top of the vector.
    // A negative magnitude is below one thousand, so its first cell is blank
    // and the minus sign takes that place. The last digit is blank only for
    // zero, which must still show a zero.
    always_comb begin
        if (last_word.err) begin
            m_seg_pos0 = ERR_SEG[0];
            m_seg_pos1 = ERR_SEG[1];
            m_seg_pos2 = ERR_SEG[2];
            m_seg_pos3 = ERR_SEG[3];
        end else begin
            m_seg_pos0 = last_word.neg ? SEG_MINUS : last_word.segs[3];
            m_seg_pos1 = last_word.segs[2];
            m_seg_pos2 = last_word.segs[1];
            m_seg_pos3 = (last_word.segs[0] == SEG_BLANK) ? DIGIT_SEG[0] : last_word.segs[0];
        end
    end

endmodule

// ===== design/ss7_cell.sv =====
// One digit cell: takes the leading decimal digit off the remainder and shifts in its pattern.
`timescale 1ns / 1ps

module ss7_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ss7_pkg::ss7_word_t in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output ss7_pkg::ss7_word_t out_word
);
    import ss7_pkg::*;

    logic      valid_reg;
    ss7_word_t word_reg;
    ss7_word_t word_next;
    logic [DIGIT_W-1:0] digit;
    logic [REM_W-1:0]   low_rem;
    logic               still_leading;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb begin
        // The remainder is always below ten thousand, so the digit is the
        // highest multiple of one thousand that does not exceed it, counted in thousands.
        digit = '0;
        for (int k = 1; k < 10; k++) begin
            if (in_word.rem >= KILO[k]) begin
                digit = DIGIT_W'(k);
            end
        end
        low_rem       = in_word.rem - KILO[digit];
        still_leading = in_word.leading && (digit == '0);

        word_next         = in_word;
        word_next.leading = still_leading;
        word_next.rem     = (low_rem << 3) + (low_rem << 1);
        word_next.segs    = {in_word.segs[NUM_POS-2:0],
                             still_leading ? SEG_BLANK : DIGIT_SEG[digit]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule
